FILE: rtl/accel_tilt_shake_detector_assert.svh
// Assertion macros for the accelerometer tilt and shake detector.
// Included by the top level only; no other dependencies.
`ifndef ACCEL_TILT_SHAKE_DETECTOR_ASSERT_SVH
`define ACCEL_TILT_SHAKE_DETECTOR_ASSERT_SVH

`ifndef SYNTHESIS
`define ATSD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ATSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ATSD_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ATSD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/atsd_pkg.sv
// Shared types and constants of the accelerometer tilt and shake detector.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
package atsd_pkg;

  localparam int GRAV_ALPHA    = 9830;
  localparam int ANGLE_GAIN    = 19661;
  localparam int DEAD_ZONE     = 6144;
  localparam int ANG_HALF_TURN = 11796480;
  localparam int QUARTER_TURN  = 5898240;
  localparam int ANG_W         = 20;
  localparam int ZW            = 27;
  localparam int DIV_STEPS     = 15;
  localparam int MAX_CORDIC    = 24;

  localparam logic [3:0] REG_STILL_LEVEL   = 4'd0;
  localparam logic [3:0] REG_SHAKE_LEVEL   = 4'd1;
  localparam logic [3:0] REG_RELEASE_LEVEL = 4'd2;
  localparam logic [3:0] REG_FACE_LEVEL    = 4'd3;
  localparam logic [3:0] REG_WINDOW_MS     = 4'd4;
  localparam logic [3:0] REG_HOLDOFF_MS    = 4'd5;
  localparam logic [3:0] REG_FACE_HOLD_MS  = 4'd6;
  localparam logic [3:0] REG_FULL_TILT     = 4'd7;

  localparam logic [3:0] MUL_GX    = 4'd0;
  localparam logic [3:0] MUL_GY    = 4'd1;
  localparam logic [3:0] MUL_GZ    = 4'd2;
  localparam logic [3:0] MUL_DX    = 4'd3;
  localparam logic [3:0] MUL_DY    = 4'd4;
  localparam logic [3:0] MUL_DZ    = 4'd5;
  localparam logic [3:0] MUL_STILL = 4'd6;
  localparam logic [3:0] MUL_SHAKE = 4'd7;
  localparam logic [3:0] MUL_REL   = 4'd8;
  localparam logic [3:0] MUL_TILT  = 4'd9;

  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_UPD_GX    = 4'd1;
  localparam logic [3:0] OP_UPD_GY    = 4'd2;
  localparam logic [3:0] OP_UPD_GZ    = 4'd3;
  localparam logic [3:0] OP_E2_SET    = 4'd4;
  localparam logic [3:0] OP_E2_ADD    = 4'd5;
  localparam logic [3:0] OP_MOVED     = 4'd6;
  localparam logic [3:0] OP_SHAKE_CMP = 4'd7;
  localparam logic [3:0] OP_EVENTS    = 4'd8;
  localparam logic [3:0] OP_COR_INIT  = 4'd9;
  localparam logic [3:0] OP_COR_ITER  = 4'd10;
  localparam logic [3:0] OP_COR_END   = 4'd11;
  localparam logic [3:0] OP_TILT_UPD  = 4'd12;
  localparam logic [3:0] OP_DIV_INIT  = 4'd13;
  localparam logic [3:0] OP_DIV_ITER  = 4'd14;
  localparam logic [3:0] OP_DIV_END   = 4'd15;

  typedef struct packed {
    logic [14:0] still_level;
    logic [14:0] shake_level;
    logic [14:0] release_level;
    logic [15:0] face_down_level;
    logic [15:0] swing_window;
    logic [15:0] report_gap;
    logic [15:0] face_hold_ms;
    logic [6:0]  full_tilt_deg;
  } atsd_cfg_t;

  typedef struct packed {
    logic       load;
    logic       emit;
    logic [3:0] mul_sel;
    logic [3:0] op;
    logic       axis;
    logic [4:0] step;
  } atsd_cmd_t;

  typedef struct packed {
    logic div_skip;
  } atsd_stat_t;

  function automatic logic signed [ZW-1:0] atsd_atan(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:  v = 27'sd2949120;
      5'd1:  v = 27'sd1740967;
      5'd2:  v = 27'sd919879;
      5'd3:  v = 27'sd466945;
      5'd4:  v = 27'sd234379;
      5'd5:  v = 27'sd117304;
      5'd6:  v = 27'sd58666;
      5'd7:  v = 27'sd29335;
      5'd8:  v = 27'sd14668;
      5'd9:  v = 27'sd7334;
      5'd10: v = 27'sd3667;
      5'd11: v = 27'sd1833;
      5'd12: v = 27'sd917;
      5'd13: v = 27'sd458;
      5'd14: v = 27'sd229;
      5'd15: v = 27'sd115;
      5'd16: v = 27'sd57;
      5'd17: v = 27'sd29;
      5'd18: v = 27'sd14;
      5'd19: v = 27'sd7;
      5'd20: v = 27'sd4;
      5'd21: v = 27'sd2;
      5'd22: v = 27'sd1;
      default: v = 27'sd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/atsd_ctrl.sv
// Sequencing controller of the tilt and shake detector.
// Drives the datapath by command words; depends on atsd_pkg.
`timescale 1ns / 1ps
module atsd_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 out_free,
  input  atsd_pkg::atsd_stat_t stat,
  output atsd_pkg::atsd_cmd_t  cmd
);
  import atsd_pkg::*;

  localparam int NSTEPS = (CORDIC_STEPS > MAX_CORDIC) ? MAX_CORDIC : CORDIC_STEPS;
  localparam logic [4:0] LAST_COR = 5'(NSTEPS - 1);
  localparam logic [4:0] LAST_DIV = 5'(DIV_STEPS - 1);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_GX    = 5'd1;
  localparam logic [4:0] ST_GY    = 5'd2;
  localparam logic [4:0] ST_GZ    = 5'd3;
  localparam logic [4:0] ST_DX    = 5'd4;
  localparam logic [4:0] ST_DY    = 5'd5;
  localparam logic [4:0] ST_DZ    = 5'd6;
  localparam logic [4:0] ST_LVS   = 5'd7;
  localparam logic [4:0] ST_LVK   = 5'd8;
  localparam logic [4:0] ST_LVR   = 5'd9;
  localparam logic [4:0] ST_EVT   = 5'd10;
  localparam logic [4:0] ST_CINIT = 5'd11;
  localparam logic [4:0] ST_CITER = 5'd12;
  localparam logic [4:0] ST_CEND  = 5'd13;
  localparam logic [4:0] ST_TMUL  = 5'd14;
  localparam logic [4:0] ST_TUPD  = 5'd15;
  localparam logic [4:0] ST_DINIT = 5'd16;
  localparam logic [4:0] ST_DITER = 5'd17;
  localparam logic [4:0] ST_DEND  = 5'd18;
  localparam logic [4:0] ST_DONE  = 5'd19;

  logic [4:0] state, state_next;
  logic       axis, axis_next;
  logic [4:0] step, step_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next  = state;
    axis_next   = axis;
    step_next   = step;
    cmd         = '0;
    cmd.axis    = axis;
    cmd.step    = step;
    cmd.mul_sel = MUL_GX;
    cmd.op      = OP_NONE;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_GX;
        end
      end
      ST_GX: begin
        cmd.mul_sel = MUL_GX;
        state_next  = ST_GY;
      end
      ST_GY: begin
        cmd.mul_sel = MUL_GY;
        cmd.op      = OP_UPD_GX;
        state_next  = ST_GZ;
      end
      ST_GZ: begin
        cmd.mul_sel = MUL_GZ;
        cmd.op      = OP_UPD_GY;
        state_next  = ST_DX;
      end
      ST_DX: begin
        cmd.mul_sel = MUL_DX;
        cmd.op      = OP_UPD_GZ;
        state_next  = ST_DY;
      end
      ST_DY: begin
        cmd.mul_sel = MUL_DY;
        cmd.op      = OP_E2_SET;
        state_next  = ST_DZ;
      end
      ST_DZ: begin
        cmd.mul_sel = MUL_DZ;
        cmd.op      = OP_E2_ADD;
        state_next  = ST_LVS;
      end
      ST_LVS: begin
        cmd.mul_sel = MUL_STILL;
        cmd.op      = OP_E2_ADD;
        state_next  = ST_LVK;
      end
      ST_LVK: begin
        cmd.mul_sel = MUL_SHAKE;
        cmd.op      = OP_MOVED;
        state_next  = ST_LVR;
      end
      ST_LVR: begin
        cmd.mul_sel = MUL_REL;
        cmd.op      = OP_SHAKE_CMP;
        state_next  = ST_EVT;
      end
      ST_EVT: begin
        cmd.op     = OP_EVENTS;
        axis_next  = 1'b0;
        state_next = ST_CINIT;
      end
      ST_CINIT: begin
        cmd.op     = OP_COR_INIT;
        step_next  = '0;
        state_next = ST_CITER;
      end
      ST_CITER: begin
        cmd.op    = OP_COR_ITER;
        step_next = step + 5'd1;
        if (step == LAST_COR) begin
          state_next = ST_CEND;
        end
      end
      ST_CEND: begin
        cmd.op     = OP_COR_END;
        state_next = ST_TMUL;
      end
      ST_TMUL: begin
        cmd.mul_sel = MUL_TILT;
        state_next  = ST_TUPD;
      end
      ST_TUPD: begin
        cmd.op = OP_TILT_UPD;
        if (axis) begin
          axis_next  = 1'b0;
          state_next = ST_DINIT;
        end else begin
          axis_next  = 1'b1;
          state_next = ST_CINIT;
        end
      end
      ST_DINIT: begin
        cmd.op     = OP_DIV_INIT;
        step_next  = '0;
        state_next = ST_DITER;
      end
      ST_DITER: begin
        cmd.op    = OP_DIV_ITER;
        step_next = step + 5'd1;
        if (stat.div_skip || step == LAST_DIV) begin
          state_next = ST_DEND;
        end
      end
      ST_DEND: begin
        cmd.op = OP_DIV_END;
        if (axis) begin
          state_next = ST_DONE;
        end else begin
          axis_next  = 1'b1;
          state_next = ST_DINIT;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      axis  <= 1'b0;
      step  <= '0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      step  <= step_next;
    end
  end

endmodule

FILE: rtl/atsd_datapath.sv
// Datapath of the tilt and shake detector: filters, shared multiplier,
// motion tests, CORDIC unit and steer divider. Depends on atsd_pkg.
`timescale 1ns / 1ps
module atsd_datapath #(
  parameter int ACCEL_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  atsd_pkg::atsd_cfg_t          cfg,
  input  atsd_pkg::atsd_cmd_t          cmd,
  output atsd_pkg::atsd_stat_t         stat,
  input  logic [ACCEL_BITS-1:0]        accel_x,
  input  logic [ACCEL_BITS-1:0]        accel_y,
  input  logic [ACCEL_BITS-1:0]        accel_z,
  input  logic [31:0]                  now_ms,
  output logic signed [15:0]           roll_angle,
  output logic signed [15:0]           pitch_angle,
  output logic signed [15:0]           steer_x,
  output logic signed [15:0]           steer_y,
  output logic signed [ACCEL_BITS-1:0] gravity_x,
  output logic signed [ACCEL_BITS-1:0] gravity_y,
  output logic signed [ACCEL_BITS-1:0] gravity_z,
  output logic                         shake_event,
  output logic                         face_down,
  output logic [31:0]                  still_for_ms
);
  import atsd_pkg::*;

  localparam int AB  = ACCEL_BITS;
  localparam int AW  = AB + 8;
  localparam int MW  = AB + 9;
  localparam int PW  = 2 * MW;
  localparam int SQW = (PW > 46) ? PW : 46;
  localparam int CW  = AW + 3;

  logic signed [AB-1:0]    xt, yt, zt;
  logic [31:0]             now_q;
  logic signed [AW-1:0]    gx, gy, gz;
  logic signed [PW-1:0]    p;
  logic [SQW-1:0]          e2;
  logic                    shake_hit, swinging, down_st, down_cand, shake_ev;
  logic [1:0]              swing_cnt;
  logic [31:0]             first_t, hold_t, moved_t, since_t;
  logic signed [CW-1:0]    cx, cy;
  logic signed [ZW-1:0]    cz;
  logic                    czero;
  logic signed [ANG_W-1:0] rnow, rs, ps;
  logic [7:0]              div_rem, div_den;
  logic [DIV_STEPS-1:0]    div_q;
  logic                    div_zero, div_sat, div_neg;
  logic signed [15:0]      st_x, st_y;

  logic signed [AB:0]      xn;
  logic signed [AB-1:0]    xsat;
  logic signed [AW-1:0]    tx, ty, tz;
  logic signed [MW-1:0]    dxv, dyv, dzv, dtv, ma, mb;
  logic signed [PW-1:0]    rnd;
  logic [SQW-1:0]          p_u, lvsq;

  assign xn   = -$signed({accel_x[AB-1], accel_x});
  assign xsat = (accel_x == {1'b1, {(AB-1){1'b0}}}) ? {1'b0, {(AB-1){1'b1}}} : xn[AB-1:0];
  assign tx   = {xt, 8'h00};
  assign ty   = {yt, 8'h00};
  assign tz   = {zt, 8'h00};
  assign dxv  = MW'(tx) - MW'(gx);
  assign dyv  = MW'(ty) - MW'(gy);
  assign dzv  = MW'(tz) - MW'(gz);
  assign dtv  = cmd.axis ? (MW'(rnow) - MW'(ps)) : (MW'(rnow) - MW'(rs));
  assign rnd  = (p + PW'(32768)) >>> 16;
  assign p_u  = SQW'($unsigned(p));
  assign lvsq = p_u << 16;

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mul_sel)
      MUL_GX: begin
        ma = dxv;
        mb = MW'(GRAV_ALPHA);
      end
      MUL_GY: begin
        ma = dyv;
        mb = MW'(GRAV_ALPHA);
      end
      MUL_GZ: begin
        ma = dzv;
        mb = MW'(GRAV_ALPHA);
      end
      MUL_DX: begin
        ma = dxv;
        mb = dxv;
      end
      MUL_DY: begin
        ma = dyv;
        mb = dyv;
      end
      MUL_DZ: begin
        ma = dzv;
        mb = dzv;
      end
      MUL_STILL: begin
        ma = MW'(cfg.still_level);
        mb = MW'(cfg.still_level);
      end
      MUL_SHAKE: begin
        ma = MW'(cfg.shake_level);
        mb = MW'(cfg.shake_level);
      end
      MUL_REL: begin
        ma = MW'(cfg.release_level);
        mb = MW'(cfg.release_level);
      end
      MUL_TILT: begin
        ma = dtv;
        mb = MW'(ANGLE_GAIN);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // Swing counting, holdoff and face-down debounce.
  logic [31:0]   dt_first, dt_hold, dt_since;
  logic          win_new, fire, down_now;
  logic [1:0]    cnt1;
  logic signed [31:0] gz_w, fdl_w;

  assign dt_first = now_q - first_t;
  assign dt_hold  = now_q - hold_t;
  assign dt_since = now_q - since_t;
  assign win_new  = (swing_cnt == 2'd0) || (dt_first > {16'h0000, cfg.swing_window});
  assign cnt1     = win_new ? 2'd1 : ((swing_cnt == 2'd3) ? 2'd3 : swing_cnt + 2'd1);
  assign fire     = (cnt1 >= 2'd2) && (dt_hold != 32'd0) && !dt_hold[31];
  assign gz_w     = 32'(gz);
  assign fdl_w    = $signed({{8{cfg.face_down_level[15]}}, cfg.face_down_level, 8'h00});
  assign down_now = gz_w < fdl_w;

  // CORDIC step.
  logic signed [CW-1:0]    gsel, xs, ys;
  logic signed [ZW-1:0]    at, zc, zr;

  assign gsel = cmd.axis ? CW'(gy) : CW'(gx);
  assign xs   = cx >>> cmd.step;
  assign ys   = cy >>> cmd.step;
  assign at   = atsd_atan(cmd.step);
  assign zc   = (cz > ZW'(ANG_HALF_TURN)) ? ZW'(ANG_HALF_TURN) :
                ((cz < -ZW'(ANG_HALF_TURN)) ? -ZW'(ANG_HALF_TURN) : cz);
  assign zr   = (zc + ZW'(16)) >>> 5;

  // Steer divider setup.
  logic signed [ANG_W-1:0] deg, absd;
  logic signed [ANG_W:0]   mag;
  logic [6:0]              ft_eff, dd;
  logic [17:0]             span;
  logic                    zero_f, sat_f;
  logic [21:0]             num;
  logic [8:0]              r2;
  logic                    qbit;
  logic [15:0]             mo;

  assign deg    = cmd.axis ? ps : rs;
  assign absd   = deg[ANG_W-1] ? -deg : deg;
  assign mag    = $signed({1'b0, absd}) - (ANG_W+1)'(DEAD_ZONE);
  assign ft_eff = (cfg.full_tilt_deg < 7'd4) ? 7'd4 : cfg.full_tilt_deg;
  assign dd     = ft_eff - 7'd3;
  assign span   = {dd, 11'h000};
  assign zero_f = mag[ANG_W] || (mag == '0);
  assign sat_f  = !zero_f && ($unsigned(mag) >= (ANG_W+1)'(span));
  assign num    = 22'({mag[17:0], 4'h0}) + 22'(dd);
  assign r2     = {div_rem, div_q[DIV_STEPS-1]};
  assign qbit   = (r2 >= 9'(div_den));
  assign mo     = div_zero ? 16'd0 : (div_sat ? 16'd16384 : 16'(div_q));

  assign stat.div_skip = div_zero | div_sat;

  always_ff @(posedge clk) begin
    p <= PW'(ma) * PW'(mb);
    if (cmd.load) begin
      xt    <= xsat;
      yt    <= accel_y;
      zt    <= accel_z;
      now_q <= now_ms;
    end
    case (cmd.op)
      OP_E2_SET: e2 <= p_u;
      OP_E2_ADD: e2 <= e2 + p_u;
      OP_COR_INIT: begin
        czero <= (gz == '0) && (gsel == '0);
        if (CW'(gz) < 0) begin
          if (gsel >= 0) begin
            cx <= gsel;
            cy <= -CW'(gz);
            cz <= ZW'(QUARTER_TURN);
          end else begin
            cx <= -gsel;
            cy <= CW'(gz);
            cz <= -ZW'(QUARTER_TURN);
          end
        end else begin
          cx <= CW'(gz);
          cy <= gsel;
          cz <= '0;
        end
      end
      OP_COR_ITER: begin
        if (!cy[CW-1]) begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + at;
        end else begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - at;
        end
      end
      OP_COR_END: rnow <= czero ? '0 : ANG_W'(zr);
      OP_DIV_INIT: begin
        div_zero <= zero_f;
        div_sat  <= sat_f;
        div_neg  <= deg[ANG_W-1];
        div_den  <= {dd, 1'b0};
        div_rem  <= 8'(num[21:DIV_STEPS]);
        div_q    <= num[DIV_STEPS-1:0];
      end
      OP_DIV_ITER: begin
        div_rem <= qbit ? 8'(r2 - 9'(div_den)) : r2[7:0];
        div_q   <= {div_q[DIV_STEPS-2:0], qbit};
      end
      OP_DIV_END: begin
        if (cmd.axis) begin
          st_y <= div_neg ? -$signed(mo) : $signed(mo);
        end else begin
          st_x <= div_neg ? -$signed(mo) : $signed(mo);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gx        <= '0;
      gy        <= '0;
      gz        <= AW'(4096 * 256);
      rs        <= '0;
      ps        <= '0;
      shake_hit <= 1'b0;
      swinging  <= 1'b0;
      swing_cnt <= '0;
      first_t   <= '0;
      hold_t    <= '0;
      moved_t   <= '0;
      down_st   <= 1'b0;
      down_cand <= 1'b0;
      since_t   <= '0;
      shake_ev  <= 1'b0;
    end else begin
      if (cmd.load) begin
        shake_ev <= 1'b0;
      end
      case (cmd.op)
        OP_UPD_GX: gx <= gx + AW'(rnd);
        OP_UPD_GY: gy <= gy + AW'(rnd);
        OP_UPD_GZ: gz <= gz + AW'(rnd);
        OP_MOVED: begin
          if (e2 > lvsq) begin
            moved_t <= now_q;
          end
        end
        OP_SHAKE_CMP: shake_hit <= (e2 > lvsq);
        OP_EVENTS: begin
          if (shake_hit) begin
            if (!swinging) begin
              swinging <= 1'b1;
              if (win_new) begin
                first_t <= now_q;
              end
              if (fire) begin
                shake_ev  <= 1'b1;
                hold_t    <= now_q + {16'h0000, cfg.report_gap};
                swing_cnt <= '0;
              end else begin
                swing_cnt <= cnt1;
              end
            end
          end else if (e2 < lvsq) begin
            swinging <= 1'b0;
          end
          if (down_now != down_cand) begin
            down_cand <= down_now;
            since_t   <= now_q;
          end else if (down_now != down_st && dt_since > {16'h0000, cfg.face_hold_ms}) begin
            down_st <= down_now;
          end
        end
        OP_TILT_UPD: begin
          if (cmd.axis) begin
            ps <= ps + ANG_W'(rnd);
          end else begin
            rs <= rs + ANG_W'(rnd);
          end
        end
        default: begin
        end
      endcase
    end
  end

  logic signed [ANG_W-1:0] rs_r, ps_r;

  assign rs_r         = rs + ANG_W'(8);
  assign ps_r         = ps + ANG_W'(8);
  assign roll_angle   = rs_r[ANG_W-1:4];
  assign pitch_angle  = ps_r[ANG_W-1:4];
  assign steer_x      = st_x;
  assign steer_y      = st_y;
  assign gravity_x    = gx[AW-1:8];
  assign gravity_y    = gy[AW-1:8];
  assign gravity_z    = gz[AW-1:8];
  assign shake_event  = shake_ev;
  assign face_down    = down_st;
  assign still_for_ms = now_q - moved_t;

endmodule

FILE: rtl/accel_tilt_shake_detector.sv
// Top level of the accelerometer tilt and shake detector.
// Holds the register file and output register; uses atsd_pkg, atsd_ctrl,
// atsd_datapath and the assertion header.
//
// Channel  Dir  Beat content
// s_*      in   one sample: accel_x, accel_y, accel_z, now_ms
// m_*      out  one result: angles, steer, gravity, still time; flags in tuser
// cfg_*    in   one register write: index and data
//
// Between acceptance and its result, a sample passes through the shared CORDIC
// unit, which runs S = min(CORDIC_STEPS, 24) steps, and the 15-step steer
// divider, each run once per axis.
// The next sample is accepted once the current result sits in the output
// register, even while that result waits for m_tready.
// Reset is synchronous and returns the filters and timers to their start values.
`timescale 1ns / 1ps
`include "accel_tilt_shake_detector_assert.svh"
module accel_tilt_shake_detector #(
  parameter int ACCEL_BITS   = 16,
  parameter int CORDIC_STEPS = 16,
  localparam int IN_W        = ((3 * ACCEL_BITS + 32 + 7) / 8) * 8,
  localparam int OUT_W       = ((96 + 3 * ACCEL_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // accel_x, accel_y, accel_z, now_ms
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // roll_angle, pitch_angle, steer_x, steer_y, gravity_x, gravity_y,
  // gravity_z, still_for_ms
  output logic [OUT_W-1:0] m_tdata,
  // shake_event, face_down
  output logic [1:0]       m_tuser,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [3:0]       cfg_index,
  input  logic [15:0]      cfg_data
);
  import atsd_pkg::*;

  localparam int AB = ACCEL_BITS;

  atsd_cfg_t  cfg;
  atsd_cmd_t  cmd;
  atsd_stat_t stat;
  logic       out_free;

  logic signed [15:0]   roll_angle, pitch_angle, steer_x, steer_y;
  logic signed [AB-1:0] gravity_x, gravity_y, gravity_z;
  logic                 shake_event, face_down;
  logic [31:0]          still_for_ms;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.still_level     <= 15'd246;
      cfg.shake_level     <= 15'd4506;
      cfg.release_level   <= 15'd1843;
      cfg.face_down_level <= 16'hF400;
      cfg.swing_window    <= 16'd700;
      cfg.report_gap      <= 16'd500;
      cfg.face_hold_ms    <= 16'd400;
      cfg.full_tilt_deg   <= 7'd30;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STILL_LEVEL:   cfg.still_level     <= cfg_data[14:0];
        REG_SHAKE_LEVEL:   cfg.shake_level     <= cfg_data[14:0];
        REG_RELEASE_LEVEL: cfg.release_level   <= cfg_data[14:0];
        REG_FACE_LEVEL:    cfg.face_down_level <= cfg_data;
        REG_WINDOW_MS:     cfg.swing_window    <= cfg_data;
        REG_HOLDOFF_MS:    cfg.report_gap      <= cfg_data;
        REG_FACE_HOLD_MS:  cfg.face_hold_ms    <= cfg_data;
        REG_FULL_TILT:     cfg.full_tilt_deg   <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  atsd_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd)
  );

  atsd_datapath #(
    .ACCEL_BITS(ACCEL_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .stat         (stat),
    .accel_x      (s_tdata[AB-1:0]),
    .accel_y      (s_tdata[2*AB-1:AB]),
    .accel_z      (s_tdata[3*AB-1:2*AB]),
    .now_ms       (s_tdata[3*AB+31:3*AB]),
    .roll_angle   (roll_angle),
    .pitch_angle  (pitch_angle),
    .steer_x      (steer_x),
    .steer_y      (steer_y),
    .gravity_x    (gravity_x),
    .gravity_y    (gravity_y),
    .gravity_z    (gravity_z),
    .shake_event  (shake_event),
    .face_down    (face_down),
    .still_for_ms (still_for_ms)
  );

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= OUT_W'({still_for_ms, gravity_z, gravity_y, gravity_x,
                         steer_y, steer_x, pitch_angle, roll_angle});
      m_tuser <= {face_down, shake_event};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  `ATSD_ASSERT_IMPLY(a_no_overwrite, clk, rst, cmd.emit, out_free)
  `ATSD_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)
  `ATSD_ASSERT_NEXT(a_emit_frees_input, clk, rst, cmd.emit, m_tvalid && s_tready)

endmodule

FILE: tb/sv/accel_tilt_shake_detector_test.sv
// Self-checking testbench for accel_tilt_shake_detector: random and directed
// samples with idle and stall patterns, checked against a built-in predictor.
// Depends on atsd_pkg and the accel_tilt_shake_detector RTL.
`timescale 1ns / 1ps
module accel_tilt_shake_detector_test;
  import atsd_pkg::*;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] steer_x;
    logic signed [15:0] steer_y;
    logic signed [15:0] grav_x;
    logic signed [15:0] grav_y;
    logic signed [15:0] grav_z;
    logic               shake;
    logic               face_down;
    logic [31:0]        still_ms;
  } tilt_result_t;

  class tilt_scoreboard;
    atsd_cfg_t    regs;
    longint       gx, gy, gz, roll_s, pitch_s;
    bit           swinging, down_state, down_cand;
    int           swing_cnt;
    logic [31:0]  first_swing, holdoff_end, last_moved, down_since;
    tilt_result_t expected_q[$];
    int           errors;
    longint       atan_steps[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
        58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7,
        4, 2, 1, 0};

    function new();
      regs = '{still_level: 15'd246, shake_level: 15'd4506, release_level: 15'd1843,
               face_down_level: 16'hF400, swing_window: 16'd700,
               report_gap: 16'd500, face_hold_ms: 16'd400, full_tilt_deg: 7'd30};
      gx = 0; gy = 0; gz = 64'sd4096 * 256; roll_s = 0; pitch_s = 0;
      swinging = 0; down_state = 0; down_cand = 0; swing_cnt = 0;
      first_swing = 0; holdoff_end = 0; last_moved = 0; down_since = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [3:0] idx, logic [15:0] data);
      case (idx)
        REG_STILL_LEVEL:   regs.still_level = data[14:0];
        REG_SHAKE_LEVEL:   regs.shake_level = data[14:0];
        REG_RELEASE_LEVEL: regs.release_level = data[14:0];
        REG_FACE_LEVEL:    regs.face_down_level = data;
        REG_WINDOW_MS:     regs.swing_window = data;
        REG_HOLDOFF_MS:    regs.report_gap = data;
        REG_FACE_HOLD_MS:  regs.face_hold_ms = data;
        REG_FULL_TILT:     regs.full_tilt_deg = data[6:0];
        default: ;
      endcase
    endfunction

    function longint smooth(longint acc, longint tgt, longint alpha);
      return acc + (((tgt - acc) * alpha + 32768) >>> 16);
    endfunction

    function longint angle_of(longint y, longint x);
      longint z, t, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; z = 90 * 65536;
        end else begin
          t = x; x = -y; y = t; z = -90 * 65536;
        end
      end
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys; y -= xs; z += atan_steps[i];
        end else begin
          x -= ys; y += xs; z -= atan_steps[i];
        end
      end
      if (z > ANG_HALF_TURN) z = ANG_HALF_TURN;
      if (z < -ANG_HALF_TURN) z = -ANG_HALF_TURN;
      return (z + 16) >>> 5;
    endfunction

    function longint steer_of(longint a);
      longint ft, span, mag, o;
      ft = regs.full_tilt_deg;
      if (ft < 4) ft = 4;
      span = (ft - 3) * 2048;
      mag = (a < 0 ? -a : a) - DEAD_ZONE;
      if (mag <= 0) return 0;
      o = (mag * 16384 + span / 2) / span;
      if (o > 16384) o = 16384;
      return a < 0 ? -o : o;
    endfunction

    function void note_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                              logic signed [15:0] az, logic [31:0] now);
      longint x, y, z, dx, dy, dz, e2, lv;
      logic [31:0] d;
      bit shake, down;
      tilt_result_t r;
      shake = 0;
      x = -longint'(ax);
      if (x > 32767) x = 32767;
      x *= 256; y = longint'(ay) * 256; z = longint'(az) * 256;
      gx = smooth(gx, x, GRAV_ALPHA);
      gy = smooth(gy, y, GRAV_ALPHA);
      gz = smooth(gz, z, GRAV_ALPHA);
      dx = x - gx; dy = y - gy; dz = z - gz;
      e2 = dx * dx + dy * dy + dz * dz;
      lv = longint'(regs.still_level) * 256;
      if (e2 > lv * lv) last_moved = now;
      lv = longint'(regs.shake_level) * 256;
      if (e2 > lv * lv) begin
        if (!swinging) begin
          swinging = 1;
          d = now - first_swing;
          if (swing_cnt == 0 || d > {16'd0, regs.swing_window}) begin
            swing_cnt = 1;
            first_swing = now;
          end else if (swing_cnt < 3) begin
            swing_cnt++;
          end
          d = now - holdoff_end;
          if (swing_cnt >= 2 && d != 0 && !d[31]) begin
            shake = 1;
            holdoff_end = now + {16'd0, regs.report_gap};
            swing_cnt = 0;
          end
        end
      end else begin
        lv = longint'(regs.release_level) * 256;
        if (e2 < lv * lv) swinging = 0;
      end
      roll_s = smooth(roll_s, angle_of(gx, gz), ANGLE_GAIN);
      pitch_s = smooth(pitch_s, angle_of(gy, gz), ANGLE_GAIN);
      down = gz < longint'($signed(regs.face_down_level)) * 256;
      d = now - down_since;
      if (down != down_cand) begin
        down_cand = down;
        down_since = now;
      end else if (down != down_state && d > {16'd0, regs.face_hold_ms}) begin
        down_state = down;
      end
      r.roll = 16'((roll_s + 8) >>> 4);
      r.pitch = 16'((pitch_s + 8) >>> 4);
      r.steer_x = 16'(steer_of(roll_s));
      r.steer_y = 16'(steer_of(pitch_s));
      r.grav_x = 16'(gx >>> 8);
      r.grav_y = 16'(gy >>> 8);
      r.grav_z = 16'(gz >>> 8);
      r.shake = shake;
      r.face_down = down_state;
      r.still_ms = now - last_moved;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string nm, longint e, longint g);
      if (e != g) begin
        errors++;
        $display("%0t mismatch %s: expected %0d actual %0d", $time, nm, e, g);
      end
    endfunction

    function void check_result(logic [143:0] d, logic [1:0] u);
      tilt_result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual %h/%b", $time, d, u);
        return;
      end
      e = expected_q.pop_front();
      compare_field("roll_angle", e.roll, $signed(d[15:0]));
      compare_field("pitch_angle", e.pitch, $signed(d[31:16]));
      compare_field("steer_x", e.steer_x, $signed(d[47:32]));
      compare_field("steer_y", e.steer_y, $signed(d[63:48]));
      compare_field("gravity_x", e.grav_x, $signed(d[79:64]));
      compare_field("gravity_y", e.grav_y, $signed(d[95:80]));
      compare_field("gravity_z", e.grav_z, $signed(d[111:96]));
      compare_field("still_for_ms", e.still_ms, d[143:112]);
      compare_field("shake_event", e.shake, u[0]);
      compare_field("face_down", e.face_down, u[1]);
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [79:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [143:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [3:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;

  tilt_scoreboard tilt_sb = new();
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_cycles = 0;
  int          cycle_count = 0;
  logic [31:0] now_ms = 0;
  int          base_x, base_y, base_z;

  accel_tilt_shake_detector i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && m_tvalid && m_tready) tilt_sb.check_result(m_tdata, m_tuser);
    if (cycle_count > 1500000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_sample(int ax, int ay, int az, logic [31:0] t);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid = 0;
      @(negedge clk);
    end
    s_tvalid = 1;
    s_tdata = {t, 16'(az), 16'(ay), 16'(ax)};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tilt_sb.note_sample(16'(ax), 16'(ay), 16'(az), t);
    @(negedge clk);
    s_tvalid = 0;
  endtask

  task automatic write_reg(logic [3:0] idx, logic [15:0] data);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tilt_sb.set_reg(idx, data);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic drain();
    while (tilt_sb.expected_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_all(int sl, int hl, int rl, int fl, int wm, int hm, int fh, int ft);
    write_reg(REG_STILL_LEVEL, 16'(sl));
    write_reg(REG_SHAKE_LEVEL, 16'(hl));
    write_reg(REG_RELEASE_LEVEL, 16'(rl));
    write_reg(REG_FACE_LEVEL, 16'(fl));
    write_reg(REG_WINDOW_MS, 16'(wm));
    write_reg(REG_HOLDOFF_MS, 16'(hm));
    write_reg(REG_FACE_HOLD_MS, 16'(fh));
    write_reg(REG_FULL_TILT, 16'(ft));
  endtask

  function automatic int jitter(int v, int amt);
    return v + $urandom_range(2 * amt) - amt;
  endfunction

  task automatic tick(int step_ms);
    now_ms = now_ms + step_ms;
  endtask

  // Segments of plausible motion: rest, shakes of two to six swings, face-down spells,
  // and occasional raw noise with arbitrary times.
  task automatic motion_segment(inout int left);
    int kind, len;
    kind = $urandom_range(99);
    if (kind < 12) begin
      len = $urandom_range(1, 3);
      repeat (len) begin
        if ($urandom_range(3) == 0) now_ms = $urandom;
        else tick($urandom_range(0, 3000));
        send_sample($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                    now_ms);
      end
    end else if (kind < 40) begin
      len = $urandom_range(3, 10);
      if ($urandom_range(2) == 0) begin
        base_x = jitter(0, 4096); base_y = jitter(0, 4096); base_z = jitter(0, 4096);
      end
      repeat (len) begin
        tick($urandom_range(10, 30));
        send_sample(jitter(base_x, 150), jitter(base_y, 150), jitter(base_z, 150), now_ms);
      end
    end else if (kind < 75) begin
      len = $urandom_range(4, 12);
      for (int i = 0; i < len; i++) begin
        tick($urandom_range(10, 60));
        if (i % 2 == 0)
          send_sample(jitter(0, 32767), jitter(0, 32767), jitter(0, 32767), now_ms);
        else
          send_sample(jitter(base_x, 100), jitter(base_y, 100), jitter(base_z, 100),
                      now_ms);
      end
    end else begin
      len = $urandom_range(5, 15);
      repeat (len) begin
        tick($urandom_range(20, 200));
        send_sample(jitter(0, 800), jitter(0, 800), jitter(-4096, 2000), now_ms);
      end
      base_z = 4096;
    end
    left -= len;
  endtask

  initial begin
    int left;
    int idle_tab[4] = '{0, 69, 0, 25};
    int stall_tab[4] = '{0, 0, 69, 25};
    base_x = 0; base_y = 0; base_z = 4096;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: zero input, full-scale extremes, negated minimum x, shakes,
    // face-down hold, timer wrap.
    send_sample(0, 0, 0, 0);
    send_sample(0, 0, 0, 0);
    send_sample(-32768, -32768, -32768, 20);
    send_sample(32767, 32767, 32767, 40);
    send_sample(-32768, 32767, -32768, 60);
    send_sample(0, 0, 4096, 80);
    send_sample(30000, 0, 4096, 100);
    send_sample(0, 0, 4096, 120);
    send_sample(-30000, 0, 4096, 140);
    send_sample(0, 0, 4096, 160);
    send_sample(30000, 0, 4096, 180);
    send_sample(0, 0, 4096, 200);
    send_sample(-30000, 0, 4096, 220);
    now_ms = 32'hFFFF_FF00;
    for (int i = 0; i < 8; i++) begin
      tick(150);
      send_sample(0, 0, -8192, now_ms);
    end
    drain();
    write_reg(4'd9, 16'hFFFF);

    for (int p = 0; p < 6; p++) begin
      case (p)
        1: write_all(0, 0, 0, 0, 0, 0, 0, 0);
        2: write_all(32767, 32767, 32767, 16'h8000, 65535, 65535, 65535, 127);
        3: write_all($urandom_range(600), $urandom_range(2000, 9000),
                     $urandom_range(300, 2000), -$urandom_range(6000),
                     $urandom_range(1000), $urandom_range(1000),
                     $urandom_range(500), $urandom_range(4, 90));
        4: write_all($urandom_range(32767), $urandom_range(32767), $urandom_range(32767),
                     -$urandom_range(32768), $urandom_range(65535),
                     $urandom_range(65535), $urandom_range(65535), $urandom_range(127));
        5: write_all(246, 4506, 1843, -3072, 700, 500, 400, 4);
        default: ;
      endcase
      idle_pct = idle_tab[p % 4];
      stall_pct = stall_tab[p % 4];
      if (p == 2) hold_cycles = 3000;
      left = 75;
      while (left > 0) motion_segment(left);
      drain();
    end

    if (tilt_sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
